[hw/rtl/sbbph_pkg.sv]
// sbbph_pkg: shared widths, defaults and register reset values for the
// spectrum band bar graph with peak hold
// no dependencies
`default_nettype none

package sbbph_pkg;

	localparam int BIN_VALUE_W = 16;
	localparam int NF_W        = 16;
	localparam int NF_COUNT    = 8;
	localparam int NF_IDX_W    = 3;
	localparam int CFG_IDX_W   = 4;

	localparam int BAND_INDEX_W = 3;
	localparam int LEVEL_W      = 4;
	localparam int LED_MASK_W   = 8;

	localparam int BANDS_DEF         = 8;
	localparam int BINS_PER_BAND_DEF = 8;
	localparam int MAX_LEVEL_DEF     = 8;

	typedef logic [NF_W-1:0] nf_t;

	localparam nf_t NF_RESET [NF_COUNT] = '{
		16'd12, 16'd4, 16'd2, 16'd3, 16'd1, 16'd1, 16'd1, 16'd2
	};

endpackage

`default_nettype wire

[hw/rtl/spectrum_band_bar_peak_hold_top.sv]
// spectrum_band_bar_peak_hold_top: band averaging, noise floor, clamp,
// peak hold and thermometer mask over a stream of spectrum bins
// depends on sbbph_pkg
//
// channel   dir   handshake              payload
// in        in    in_valid / in_ready    bin_value
// out       out   out_valid / out_ready  band_index, new_level, held_level, led_mask
// cfg       in    cfg_valid / cfg_ready  cfg_index, cfg_data (noise floors 0..7)
//
// one bin beat is accepted per cycle unless a stall holds the input stage; a band's
// result reaches the output register through the input, sum, divide and level stages
// the divide stage is a single registered reciprocal multiply
// reset clears counters, the running sum, held levels and all stage valids;
// noise floors return to their defaults
// a stall on the output backs up stage by stage; bins that end no band keep
// flowing while later stages are full
`default_nettype none

module spectrum_band_bar_peak_hold_top #(
	parameter int BANDS         = sbbph_pkg::BANDS_DEF,
	parameter int BINS_PER_BAND = sbbph_pkg::BINS_PER_BAND_DEF,
	parameter int MAX_LEVEL     = sbbph_pkg::MAX_LEVEL_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,

	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [sbbph_pkg::BIN_VALUE_W-1:0]   bin_value,

	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic      [sbbph_pkg::BAND_INDEX_W-1:0]  band_index,
	output logic      [sbbph_pkg::LEVEL_W-1:0]       new_level,
	output logic      [sbbph_pkg::LEVEL_W-1:0]       held_level,
	output logic      [sbbph_pkg::LED_MASK_W-1:0]    led_mask,

	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [sbbph_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sbbph_pkg::NF_W-1:0]          cfg_data
);

	import sbbph_pkg::*;

	localparam int BIN_W    = (BINS_PER_BAND > 1) ? $clog2(BINS_PER_BAND) : 1;
	localparam int BAND_W   = (BANDS > 1) ? $clog2(BANDS) : 1;
	localparam int LOG_B    = $clog2(BINS_PER_BAND);
	localparam int SUM_W    = BIN_VALUE_W + LOG_B;
	localparam int RECIP_SH = SUM_W + LOG_B;
	localparam int RECIP_W  = SUM_W + 1;
	localparam int PROD_W   = SUM_W + RECIP_W;
	localparam int LVL_W    = $clog2(MAX_LEVEL + 1);
	localparam int CMP_W    = 5;

	// exact floor(sum / BINS_PER_BAND) for any SUM_W-bit sum
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
		((64'd1 << RECIP_SH) + 64'(BINS_PER_BAND) - 64'd1) / 64'(BINS_PER_BAND));

	// configuration
	nf_t nf_q [NF_COUNT];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NF_COUNT; i++) nf_q[i] <= NF_RESET[i];
		end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NF_COUNT))) begin
			nf_q[cfg_index[NF_IDX_W-1:0]] <= cfg_data;
		end
	end

	// stage control
	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;
	logic last_s1;

	assign adv3     = v_s3 && (!out_valid || out_ready);
	assign adv2     = v_s2 && (!v_s3 || adv3);
	assign adv1     = v_s1 && (!last_s1 || !v_s2 || adv2);
	assign in_ready = !v_s1 || adv1;

	// frame position
	logic [BIN_W-1:0]  bin_cnt_q;
	logic [BAND_W-1:0] band_cnt_q;
	logic              last_bin;

	assign last_bin = (bin_cnt_q == BIN_W'(BINS_PER_BAND - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_cnt_q  <= '0;
			band_cnt_q <= '0;
		end else if (in_valid && in_ready) begin
			if (last_bin) begin
				bin_cnt_q  <= '0;
				band_cnt_q <= (band_cnt_q == BAND_W'(BANDS - 1)) ? '0 : band_cnt_q + 1'b1;
			end else begin
				bin_cnt_q <= bin_cnt_q + 1'b1;
			end
		end
	end

	// stage 1: input register
	logic [BIN_VALUE_W-1:0] bin_s1;
	logic [BAND_W-1:0]      band_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			bin_s1  <= bin_value;
			last_s1 <= last_bin;
			band_s1 <= band_cnt_q;
		end
	end

	// stage 2: band sum, only band-closing beats enter
	logic [SUM_W-1:0]  band_sum_q;
	logic [SUM_W-1:0]  sum_next;
	logic [SUM_W-1:0]  sum_s2;
	logic [BAND_W-1:0] band_s2;

	assign sum_next = band_sum_q + SUM_W'(bin_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_sum_q <= '0;
			v_s2       <= 1'b0;
		end else begin
			if (adv1) band_sum_q <= last_s1 ? '0 : sum_next;
			if (adv1 && last_s1) v_s2 <= 1'b1;
			else if (adv2)       v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && last_s1) begin
			sum_s2  <= sum_next;
			band_s2 <= band_s1;
		end
	end

	// stage 3: average by reciprocal multiply
	logic [PROD_W-1:0]      prod;
	logic [BIN_VALUE_W-1:0] avg_s3;
	logic [BAND_W-1:0]      band_s3;

	assign prod = PROD_W'(sum_s2) * PROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv2) begin
			v_s3 <= 1'b1;
		end else if (adv3) begin
			v_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			avg_s3  <= prod[RECIP_SH +: BIN_VALUE_W];
			band_s3 <= band_s2;
		end
	end

	// level, peak hold and mask
	logic [LVL_W-1:0]      held_q [BANDS];
	logic [NF_W-1:0]       nf_cur;
	logic [NF_W-1:0]       diff;
	logic [LVL_W-1:0]      level;
	logic [LVL_W-1:0]      held_old;
	logic [LVL_W-1:0]      held_new;
	logic [CMP_W-1:0]      held_ext;
	logic [LED_MASK_W-1:0] mask;

	always_comb begin
		nf_cur   = nf_q[NF_IDX_W'(band_s3)];
		diff     = avg_s3 - nf_cur;
		if (avg_s3 < nf_cur) begin
			level = '0;
		end else if (diff > NF_W'(MAX_LEVEL)) begin
			level = LVL_W'(MAX_LEVEL);
		end else begin
			level = diff[LVL_W-1:0];
		end
		held_old = held_q[band_s3];
		if (level >= held_old) begin
			held_new = level;
		end else if (held_old != '0) begin
			held_new = held_old - 1'b1;
		end else begin
			held_new = held_old;
		end
		held_ext = CMP_W'(held_new);
		for (int k = 0; k < LED_MASK_W; k++) mask[k] = (held_ext > CMP_W'(k));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BANDS; i++) held_q[i] <= '0;
			out_valid <= 1'b0;
		end else begin
			if (adv3) held_q[band_s3] <= held_new;
			if (adv3)           out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			band_index <= BAND_INDEX_W'(band_s3);
			new_level  <= LEVEL_W'(level);
			held_level <= LEVEL_W'(held_new);
			led_mask   <= mask;
		end
	end

`ifndef SYNTHESIS
	// held level never falls below the fresh level of the same band
	a_held_ge_new: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (held_level >= new_level))
		else $error("held level below new level");

	// mask is empty exactly when the held level is zero
	a_mask_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((held_level == '0) == (led_mask == '0)))
		else $error("led mask disagrees with held level");

	// the running sum restarts after a band closes
	a_sum_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv1 && last_s1) |=> (band_sum_q == '0))
		else $error("band sum not cleared at band end");

	// a result only moves forward when its next stage has room
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !adv3) |-> !adv2)
		else $error("stage 3 overwritten while stalled");

	a_band_range: assert property (@(posedge clk) disable iff (!arst_n)
		band_cnt_q <= BAND_W'(BANDS - 1))
		else $error("band counter out of range");
`endif

endmodule

`default_nettype wire

[test/tb_spectrum_band_bar_peak_hold_top.sv]
`timescale 1ns / 1ps
// tb_spectrum_band_bar_peak_hold_top: self-checking bench for the band bar graph with peak hold
// directed table, then random bins under changing noise floors and idle patterns
// depends on sbbph_pkg and spectrum_band_bar_peak_hold_top

module tb_spectrum_band_bar_peak_hold_top;
	import sbbph_pkg::*;

	localparam int BINS          = BINS_PER_BAND_DEF;
	localparam int FRAME_BINS    = BANDS_DEF * BINS_PER_BAND_DEF;
	localparam int PIPE_LATENCY  = 4;
	localparam int DRAIN_PAUSE   = PIPE_LATENCY + 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SEGMENTS      = 6;
	localparam int SEGMENT_BINS  = 200;
	localparam int DIR_ROWS      = 26;

	typedef struct packed {
		logic [BAND_INDEX_W-1:0] band;
		logic [LEVEL_W-1:0]      new_lvl;
		logic [LEVEL_W-1:0]      held_lvl;
		logic [LED_MASK_W-1:0]   mask;
	} band_result_t;

	typedef enum logic {ROW_BIN, ROW_CFG} row_kind_t;
	typedef enum {SHAPE_NEAR_FLOOR, SHAPE_WIDE, SHAPE_EXTREME} band_shape_t;

	typedef struct {
		row_kind_t           kind;
		logic [CFG_IDX_W-1:0] index;
		logic [NF_W-1:0]     value;
		bit                  typed;
		band_result_t        result;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [BIN_VALUE_W-1:0] bin_value;
	logic out_valid;
	logic out_ready;
	logic [BAND_INDEX_W-1:0] band_index;
	logic [LEVEL_W-1:0] new_level;
	logic [LEVEL_W-1:0] held_level;
	logic [LED_MASK_W-1:0] led_mask;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [NF_W-1:0] cfg_data;

	// bench copy of the block state
	nf_t         floors [NF_COUNT];
	int unsigned acc_sum;
	int unsigned bin_pos;
	int unsigned held_by_band [BANDS_DEF];

	band_result_t expected_bands [$];
	int mismatch_count;
	int send_idle_pct;
	int recv_idle_pct;
	int idle_cycles;

	band_shape_t band_shape;
	int          band_base;

	// band 0 saturates, band 1 stays dark, band 2 averages 42/8 = 5 over a floor of 2;
	// the out-of-range writes would hit floors 0 and 7 if the index were truncated
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_CFG, 4'd8,  16'hffff, 1'b0, '0},
		'{ROW_CFG, 4'd15, 16'h0000, 1'b0, '0},
		'{ROW_BIN, 4'd0,  16'hffff, 1'b0, '0},
		'{ROW_BIN, 4'd0,  16'hffff, 1'b0, '0},
		'{ROW_BIN, 4'd0,  16'hffff, 1'b0, '0},
		'{ROW_BIN, 4'd0,  16'hffff, 1'b0, '0},
		'{ROW_BIN, 4'd0,  16'hffff, 1'b0, '0},
		'{ROW_BIN, 4'd0,  16'hffff, 1'b0, '0},
		'{ROW_BIN, 4'd0,  16'hffff, 1'b0, '0},
		'{ROW_BIN, 4'd0,  16'hffff, 1'b1, '{3'd0, 4'd8, 4'd8, 8'hff}},
		'{ROW_BIN, 4'd0,  16'h0000, 1'b0, '0},
		'{ROW_BIN, 4'd0,  16'h0000, 1'b0, '0},
		'{ROW_BIN, 4'd0,  16'h0000, 1'b0, '0},
		'{ROW_BIN, 4'd0,  16'h0000, 1'b0, '0},
		'{ROW_BIN, 4'd0,  16'h0000, 1'b0, '0},
		'{ROW_BIN, 4'd0,  16'h0000, 1'b0, '0},
		'{ROW_BIN, 4'd0,  16'h0000, 1'b0, '0},
		'{ROW_BIN, 4'd0,  16'h0000, 1'b1, '{3'd1, 4'd0, 4'd0, 8'h00}},
		'{ROW_BIN, 4'd0,  16'd5,    1'b0, '0},
		'{ROW_BIN, 4'd0,  16'd5,    1'b0, '0},
		'{ROW_BIN, 4'd0,  16'd5,    1'b0, '0},
		'{ROW_BIN, 4'd0,  16'd5,    1'b0, '0},
		'{ROW_BIN, 4'd0,  16'd5,    1'b0, '0},
		'{ROW_BIN, 4'd0,  16'd5,    1'b0, '0},
		'{ROW_BIN, 4'd0,  16'd5,    1'b0, '0},
		'{ROW_BIN, 4'd0,  16'd7,    1'b1, '{3'd2, 4'd3, 4'd3, 8'h07}}
	};

	spectrum_band_bar_peak_hold_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.bin_value  (bin_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.band_index (band_index),
		.new_level  (new_level),
		.held_level (held_level),
		.led_mask   (led_mask),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// accumulate one bin; on a band's last bin compute level, peak hold and mask
	function automatic bit predict_band(input logic [BIN_VALUE_W-1:0] v,
			output band_result_t r);
		int unsigned band;
		int unsigned avg;
		int unsigned lvl;
		int unsigned hold;
		bit          last;
		r = '0;
		acc_sum = acc_sum + int'(v);
		last = ((bin_pos + 1) % BINS) == 0;
		band = bin_pos / BINS;
		bin_pos = (bin_pos + 1 >= FRAME_BINS) ? 0 : bin_pos + 1;
		if (!last)
			return 1'b0;
		avg = acc_sum / BINS;
		acc_sum = 0;
		lvl = (avg < int'(floors[band])) ? 0 : avg - int'(floors[band]);
		if (lvl > MAX_LEVEL_DEF)
			lvl = MAX_LEVEL_DEF;
		hold = held_by_band[band];
		if (lvl >= hold)
			hold = lvl;
		else if (hold != 0)
			hold = hold - 1;
		held_by_band[band] = hold;
		r.band = 3'(band);
		r.new_lvl = 4'(lvl);
		r.held_lvl = 4'(hold);
		for (int k = 0; k < LED_MASK_W; k++)
			r.mask[k] = (hold > k);
		return 1'b1;
	endfunction

	// most bands sit just above their floor so every level and the decay get exercised
	function automatic logic [BIN_VALUE_W-1:0] next_bin_value();
		int pick;
		int v;
		if (bin_pos % BINS == 0) begin
			pick = int'($urandom_range(0, 99));
			band_shape = (pick < 70) ? SHAPE_NEAR_FLOOR
				: (pick < 85) ? SHAPE_WIDE : SHAPE_EXTREME;
			band_base = int'(floors[bin_pos / BINS]) + int'($urandom_range(0, 10)) - 1;
		end
		case (band_shape)
			SHAPE_NEAR_FLOOR: v = band_base - 2 + int'($urandom_range(0, 4));
			SHAPE_WIDE:       v = int'($urandom_range(0, 65535));
			default:          v = ($urandom_range(0, 1) != 0) ? 65535 : 0;
		endcase
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return 16'(v);
	endfunction

	task automatic send_bin(input logic [BIN_VALUE_W-1:0] v, input bit typed,
			input band_result_t typed_r);
		band_result_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		bin_value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (predict_band(v, r))
			expected_bands.push_back(typed ? typed_r : r);
	endtask

	// cfg_valid is left high; the caller drops it after the last write of a batch
	task automatic write_floor(input logic [CFG_IDX_W-1:0] idx, input logic [NF_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx < NF_COUNT)
			floors[idx[NF_IDX_W-1:0]] = data;
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_bands.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	task automatic note_mismatch(input bit have_exp, input band_result_t e,
			input band_result_t a);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			if (have_exp)
				$display({"mismatch: expected band %0d new %0d held %0d mask %02h, ",
					"got band %0d new %0d held %0d mask %02h"},
					e.band, e.new_lvl, e.held_lvl, e.mask,
					a.band, a.new_lvl, a.held_lvl, a.mask);
			else
				$display("unexpected beat: band %0d new %0d held %0d mask %02h",
					a.band, a.new_lvl, a.held_lvl, a.mask);
		end
	endtask

	always @(posedge clk) begin : check_out
		band_result_t e;
		band_result_t a;
		if (arst_n && out_valid && out_ready) begin
			a = {band_index, new_level, held_level, led_mask};
			if (expected_bands.size() == 0) begin
				note_mismatch(1'b0, '0, a);
			end else begin
				e = expected_bands.pop_front();
				if (a.band !== e.band || a.new_lvl !== e.new_lvl || a.held_lvl !== e.held_lvl
						|| a.mask !== e.mask)
					note_mismatch(1'b1, e, a);
			end
		end
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_spectrum_band_bar_peak_hold_top: done, errors");
				$finish;
			end
		end
	end

	initial begin
		bit prev_cfg;
		logic [NF_W-1:0] val;
		arst_n = 1'b0;
		in_valid = 1'b0;
		bin_value = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_cycles = 0;
		mismatch_count = 0;
		send_idle_pct = 17;
		recv_idle_pct = 87;
		band_shape = SHAPE_NEAR_FLOOR;
		band_base = 0;
		for (int i = 0; i < NF_COUNT; i++)
			floors[i] = NF_RESET[i];
		for (int i = 0; i < BANDS_DEF; i++)
			held_by_band[i] = 0;
		acc_sum = 0;
		bin_pos = 0;
		prev_cfg = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				if (!prev_cfg)
					drain_pipeline();
				write_floor(dir_rows[i].index, dir_rows[i].value);
				prev_cfg = 1'b1;
			end else begin
				if (prev_cfg)
					cfg_valid <= 1'b0;
				send_bin(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].result);
				prev_cfg = 1'b0;
			end
		end

		// floors all zero, then all ones so held levels decay, then random settings
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg / 2)
				0: begin
					send_idle_pct = 17;
					recv_idle_pct = 87;
				end
				1: begin
					send_idle_pct = 87;
					recv_idle_pct = 17;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			drain_pipeline();
			for (int i = 0; i < NF_COUNT; i++) begin
				case (seg)
					0: val = '0;
					1: val = '1;
					default: val = ($urandom_range(0, 3) == 0) ? 16'($urandom)
						: 16'($urandom_range(0, 16));
				endcase
				write_floor(4'(i), val);
			end
			write_floor(4'($urandom_range(NF_COUNT, 15)), 16'($urandom));
			cfg_valid <= 1'b0;
			repeat (SEGMENT_BINS) send_bin(next_bin_value(), 1'b0, '0);
		end

		drain_pipeline();
		if (mismatch_count == 0 && expected_bands.size() == 0)
			$display("tb_spectrum_band_bar_peak_hold_top: done, clean");
		else
			$display("tb_spectrum_band_bar_peak_hold_top: done, errors");
		$finish;
	end

endmodule
